### sv/shte_pkg.sv
`default_nettype none
package shte_pkg;
  localparam int SLOTS_MAX = 1024;
  localparam int SLOT_W = 10;
  localparam int CNT_W = 11;
  localparam int GRP_W = 8;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int HASH_W = 64;

  localparam logic [1:0] OP_FIND = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [2:0] ST_FOUND = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_DELETED = 3'd2;
  localparam logic [2:0] ST_MISS = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;

  localparam logic [7:0] TAG_EMPTY = 8'h80;
  localparam logic [7:0] TAG_DELETED = 8'hfe;
  localparam logic [7:0] TAG_MASK = 8'h7f;
endpackage
`default_nettype wire

### sv/shte_ram.sv
`default_nettype none
module shte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### sv/shte_mod.sv
`default_nettype none
// Serial remainder: one hash bit per cycle, restoring compare-subtract.
module shte_mod (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               go,
  input  wire logic [shte_pkg::HASH_W-8:0]        dividend,
  input  wire logic [shte_pkg::CNT_W-1:0]         divisor,
  output logic                                    done,
  output logic [shte_pkg::SLOT_W-1:0]             rem
);
  logic [shte_pkg::HASH_W-8:0] sh_r;
  logic [shte_pkg::CNT_W-1:0] rem_r;
  logic [5:0] cnt_r;
  logic busy_r;
  logic [shte_pkg::CNT_W:0] trial;

  assign trial = {rem_r, sh_r[shte_pkg::HASH_W-8]};
  assign rem = rem_r[shte_pkg::SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        sh_r <= dividend;
        rem_r <= '0;
        cnt_r <= 6'd57;
      end else if (busy_r) begin
        sh_r <= {sh_r[shte_pkg::HASH_W-9:0], 1'b0};
        if (trial >= {1'b0, divisor})
          rem_r <= shte_pkg::CNT_W'(trial - {1'b0, divisor});
        else
          rem_r <= shte_pkg::CNT_W'(trial);
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### sv/swiss_hash_table_engine_core.sv
`default_nettype none
// Swiss-style hash table: up to 1024 slots, 7-bit tags, probed in aligned groups of four.
// A request starts when start is high and busy is low; busy stays high at least
// until the single result beat appears on out_* with out_valid high for one cycle
// (it cannot be stalled). A request first finds the home-slot remainder (one hash
// bit per cycle through the serial remainder unit), then makes two passes over the
// probe sequence at one slot per cycle through the single tag/key/value RAM port:
// a lookup pass of n slots and, for an insert miss, a free-slot pass of up to n
// slots. Clear, a slots_in_use write and reset each sweep all 1024 entries of the
// tag RAM, during which busy is high.
module swiss_hash_table_engine_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [63:0] in_hash_value,
  input  wire logic [31:0] in_search_key,
  input  wire logic [31:0] in_write_value,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [9:0]       out_slot_index,
  output logic [31:0]      out_read_value,
  output logic [10:0]      out_occupied_count,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MOD   = 7'b0000010,
    S_LOOK  = 7'b0000100,
    S_LDONE = 7'b0001000,
    S_FREE  = 7'b0010000,
    S_FDONE = 7'b0100000,
    S_CLR   = 7'b1000000
  } state_t;

  state_t state_r;
  logic [10:0] cfg_slots_r, n_r, live_r;
  logic [1:0] op_r;
  logic [6:0] tag_r;
  logic [31:0] key_r, val_r;
  logic [9:0] home_r, step_r, clr_r;
  logic [10:0] cnt_r;         // slots issued
  logic [10:0] chk_r;         // slots checked
  logic [9:0] p_d1_r;         // address of the slot in the RAM output
  logic v_d1_r;
  logic hit_r;
  logic [9:0] hit_slot_r;
  logic cfg_wr;

  // Probe address: group base of (home + aligned step) mod n, plus lane.
  logic [10:0] gsum;
  logic [10:0] gwrap;
  logic [9:0] probe_addr;
  assign gsum = {1'b0, home_r} + {1'b0, step_r[9:2], 2'b00};
  assign gwrap = (gsum >= n_r) ? gsum - n_r : gsum;
  assign probe_addr = {gwrap[9:2], step_r[1:0]};

  // Effective slot count from the register.
  logic [10:0] n_eff;
  always_comb begin
    n_eff = {cfg_slots_r[10:2], 2'b00};
    if (n_eff < 11'd4) n_eff = 11'd4;
    if (n_eff > 11'd1024) n_eff = 11'd1024;
  end

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && paddr[2] == 1'b0;
  assign prdata = {21'd0, cfg_slots_r};

  // Remainder unit
  logic mod_go, mod_done;
  logic [9:0] mod_rem;
  shte_mod u_mod (
    .clk(clk), .rst_n(rst_n), .go(mod_go), .dividend(in_hash_value[63:7]),
    .divisor(n_eff), .done(mod_done), .rem(mod_rem)
  );

  // RAMs
  logic tag_we, kv_we;
  logic [9:0] tag_waddr;
  logic [7:0] tag_wdata, tag_rdata;
  logic [31:0] key_rdata, val_rdata;
  shte_ram #(.WIDTH(8), .DEPTH(1024)) u_tag (
    .clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
    .raddr(probe_addr), .rdata(tag_rdata)
  );
  shte_ram #(.WIDTH(32), .DEPTH(1024)) u_key (
    .clk(clk), .we(kv_we), .waddr(p_d1_r), .wdata(key_r),
    .raddr(probe_addr), .rdata(key_rdata)
  );
  shte_ram #(.WIDTH(32), .DEPTH(1024)) u_val (
    .clk(clk), .we(kv_we), .waddr(p_d1_r), .wdata(val_r),
    .raddr(probe_addr), .rdata(val_rdata)
  );

  logic is_match, is_free;
  assign is_match = v_d1_r && tag_rdata == {1'b0, tag_r} && key_rdata == key_r;
  assign is_free = v_d1_r && tag_rdata[7];

  assign busy = state_r != S_IDLE;
  assign mod_go = state_r == S_IDLE && start && in_opcode != shte_pkg::OP_CLEAR && !cfg_wr;

  always_comb begin
    tag_we = 1'b0;
    tag_waddr = p_d1_r;
    tag_wdata = {1'b0, tag_r};
    kv_we = 1'b0;
    unique case (state_r)
      S_CLR: begin
        tag_we = 1'b1;
        tag_waddr = clr_r;
        tag_wdata = shte_pkg::TAG_EMPTY;
      end
      S_LDONE: begin
        tag_we = hit_r && op_r == shte_pkg::OP_DELETE;
        tag_waddr = hit_slot_r;
        tag_wdata = shte_pkg::TAG_DELETED;
      end
      S_FREE: begin
        tag_we = is_free;
        kv_we = is_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      cfg_slots_r <= 11'd1024;
      live_r <= '0;
      out_valid <= 1'b0;
      v_d1_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      v_d1_r <= 1'b0;
      if (cfg_wr) begin
        cfg_slots_r <= pwdata[10:0];
        live_r <= '0;
        clr_r <= '0;
        state_r <= S_CLR;
      end else begin
        unique case (state_r)
          S_IDLE: begin
            if (start) begin
              op_r <= in_opcode;
              tag_r <= in_hash_value[6:0];
              key_r <= in_search_key;
              val_r <= in_write_value;
              n_r <= n_eff;
              hit_r <= 1'b0;
              if (in_opcode == shte_pkg::OP_CLEAR) begin
                live_r <= '0;
                clr_r <= '0;
                out_valid <= 1'b1;
                out_status <= shte_pkg::ST_CLEARED;
                out_slot_index <= '0;
                out_read_value <= '0;
                out_occupied_count <= '0;
                state_r <= S_CLR;
              end else begin
                state_r <= S_MOD;
              end
            end
          end
          S_MOD: if (mod_done) begin
            home_r <= mod_rem;
            step_r <= '0;
            cnt_r <= '0;
            chk_r <= '0;
            state_r <= S_LOOK;
          end
          S_LOOK: begin
            // issue one slot a cycle; check the one read last cycle
            if (cnt_r != n_r) begin
              step_r <= step_r + 10'd1;
              cnt_r <= cnt_r + 11'd1;
              v_d1_r <= 1'b1;
              p_d1_r <= probe_addr;
            end
            if (v_d1_r) chk_r <= chk_r + 11'd1;
            if (is_match && !hit_r) begin
              hit_r <= 1'b1;
              hit_slot_r <= p_d1_r;
              out_read_value <= val_rdata;
            end
            if (cnt_r == n_r && !v_d1_r) state_r <= S_LDONE;
          end
          S_LDONE: begin
            if (hit_r || op_r != shte_pkg::OP_INSERT) begin
              out_valid <= 1'b1;
              out_slot_index <= hit_r ? hit_slot_r : 10'd0;
              if (!hit_r) out_read_value <= '0;
              if (hit_r && op_r == shte_pkg::OP_DELETE) begin
                out_status <= shte_pkg::ST_DELETED;
                live_r <= (live_r != 0) ? live_r - 11'd1 : live_r;
                out_occupied_count <= (live_r != 0) ? live_r - 11'd1 : live_r;
              end else begin
                out_status <= hit_r ? shte_pkg::ST_FOUND : shte_pkg::ST_MISS;
                out_occupied_count <= live_r;
              end
              state_r <= S_IDLE;
            end else begin
              step_r <= '0;
              cnt_r <= '0;
              state_r <= S_FREE;
            end
          end
          S_FREE: begin
            if (is_free) begin
              // claimed: write done this edge by comb enables
              live_r <= live_r + 11'd1;
              out_valid <= 1'b1;
              out_status <= shte_pkg::ST_INSERTED;
              out_slot_index <= p_d1_r;
              out_read_value <= val_r;
              out_occupied_count <= live_r + 11'd1;
              state_r <= S_FDONE;
            end else if (cnt_r != n_r) begin
              step_r <= step_r + 10'd1;
              cnt_r <= cnt_r + 11'd1;
              v_d1_r <= 1'b1;
              p_d1_r <= probe_addr;
            end else if (!v_d1_r) begin
              out_valid <= 1'b1;
              out_status <= shte_pkg::ST_FULL;
              out_slot_index <= '0;
              out_read_value <= '0;
              out_occupied_count <= live_r;
              state_r <= S_IDLE;
            end
          end
          S_FDONE: state_r <= S_IDLE;
          S_CLR: begin
            clr_r <= clr_r + 10'd1;
            if (clr_r == 10'd1023) state_r <= S_IDLE;
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  // Slowest item: the serial remainder plus two full passes over 1024 slots;
  // clears and register writes sweep all 1024 tag entries. Keep the limit far above that
  // for every item taking the slow path.
  localparam int unsigned CYCLE_LIMIT = 20_000_000;
  localparam logic [2:0] REG_SLOTS_ADDR = 3'd0;
  localparam int unsigned POOL_MAX = 48;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  slot;
    logic [31:0] rval;
    logic [10:0] count;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_opcode = shte_pkg::OP_FIND;
  logic [63:0] in_hash_value = '0;
  logic [31:0] in_search_key = '0;
  logic [31:0] in_write_value = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [9:0]  out_slot_index;
  logic [31:0] out_read_value;
  logic [10:0] out_occupied_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  swiss_hash_table_engine_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_hash_value(in_hash_value),
    .in_search_key(in_search_key), .in_write_value(in_write_value),
    .out_valid(out_valid), .out_status(out_status), .out_slot_index(out_slot_index),
    .out_read_value(out_read_value), .out_occupied_count(out_occupied_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Shadow table: tags, keys, values, live entries and the slot register.
  logic [7:0]  tag_mem [shte_pkg::SLOTS_MAX];
  logic [31:0] key_mem [shte_pkg::SLOTS_MAX];
  logic [31:0] val_mem [shte_pkg::SLOTS_MAX];
  int unsigned live_cnt;
  logic [10:0] slots_reg;

  outcome_t    pending_results[$];
  logic [63:0] pool_hash[$];
  logic [31:0] pool_key[$];
  int unsigned sender_idle_pct;
  int unsigned cycle_cnt;
  bit          failed;

  function automatic void empty_table();
    for (int i = 0; i < shte_pkg::SLOTS_MAX; i++) tag_mem[i] = shte_pkg::TAG_EMPTY;
    live_cnt = 0;
    pool_hash.delete();
    pool_key.delete();
  endfunction

  // Round the register down to whole groups and clamp to 4..SLOTS_MAX.
  function automatic int unsigned table_span();
    int unsigned n;
    n = slots_reg & ~11'd3;
    if (n < 4) n = 4;
    if (n > shte_pkg::SLOTS_MAX) n = shte_pkg::SLOTS_MAX;
    return n;
  endfunction

  function automatic int unsigned probe_slot(int unsigned home, int unsigned s, int unsigned n);
    int unsigned base;
    base = ((home + (s & ~32'd3)) % n) & ~32'd3;
    return base + (s & 3);
  endfunction

  function automatic outcome_t predict_table_op(logic [1:0] op, logic [63:0] h,
                                                logic [31:0] k, logic [31:0] v);
    outcome_t    r;
    int unsigned n, home, p;
    int          hit;
    logic [7:0]  tg;
    n = table_span();
    home = (h >> 7) % n;
    tg = {1'b0, h[6:0]};
    r = '{status: shte_pkg::ST_MISS, slot: '0, rval: '0, count: '0};
    hit = -1;
    if (op == shte_pkg::OP_CLEAR) begin
      empty_table();
      r.status = shte_pkg::ST_CLEARED;
    end else begin
      for (int unsigned s = 0; s < n; s++) begin
        p = probe_slot(home, s, n);
        if (tag_mem[p] == tg && key_mem[p] == k) begin
          hit = p;
          break;
        end
      end
      if (hit >= 0) begin
        r.slot = hit;
        r.rval = val_mem[hit];
        if (op == shte_pkg::OP_DELETE) begin
          tag_mem[hit] = shte_pkg::TAG_DELETED;
          if (live_cnt > 0) live_cnt--;
          r.status = shte_pkg::ST_DELETED;
        end else begin
          r.status = shte_pkg::ST_FOUND;
        end
      end else if (op == shte_pkg::OP_INSERT) begin
        r.status = shte_pkg::ST_FULL;
        // claim the first empty or deleted slot in probe order
        for (int unsigned s = 0; s < n; s++) begin
          p = probe_slot(home, s, n);
          if (tag_mem[p][7]) begin
            tag_mem[p] = tg;
            key_mem[p] = k;
            val_mem[p] = v;
            live_cnt++;
            r.status = shte_pkg::ST_INSERTED;
            r.slot = p;
            r.rval = v;
            break;
          end
        end
      end
    end
    r.count = live_cnt;
    return r;
  endfunction

  // Call at a rising edge. Hold start until a beat is taken, then leave it high;
  // sender_gap lowers it when the sender idles.
  task automatic send_item(logic [1:0] op, logic [63:0] h, logic [31:0] k, logic [31:0] v);
    start <= 1'b1;
    in_opcode <= op;
    in_hash_value <= h;
    in_search_key <= k;
    in_write_value <= v;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_table_op(op, h, k, v));
    if (op == shte_pkg::OP_INSERT && pool_hash.size() < POOL_MAX) begin
      pool_hash.push_back(h);
      pool_key.push_back(k);
    end
    sender_gap();
  endtask

  task automatic sender_gap();
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Drop start first so the last item is not taken a second time.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Two-phase register write; the table is cleared by any write with paddr[2] low.
  task automatic write_slots(logic [10:0] value);
    drain_results();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= REG_SLOTS_ADDR;
    pwdata <= {21'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    slots_reg = value;
    empty_table();
  endtask

  // Compare every result beat against the oldest prediction.
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d slot=%0d value=%h count=%0d", $time,
                 out_status, out_slot_index, out_read_value, out_occupied_count);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          failed = 1'b1;
        end
        if (out_slot_index !== want.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, want.slot, out_slot_index);
          failed = 1'b1;
        end
        if (out_read_value !== want.rval) begin
          $display("%0t: value expected %h actual %h", $time, want.rval, out_read_value);
          failed = 1'b1;
        end
        if (out_occupied_count !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count,
                   out_occupied_count);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Extremes on the full table: all-zero and all-one fields, duplicates,
  // a miss, delete then reuse of the deleted slot, and clear.
  task automatic test_basic_ops();
    send_item(shte_pkg::OP_INSERT, 64'd0, 32'd0, 32'd0);
    send_item(shte_pkg::OP_INSERT, '1, '1, '1);
    send_item(shte_pkg::OP_FIND, 64'd0, 32'd0, 32'h1234_5678);
    send_item(shte_pkg::OP_FIND, '1, '1, 32'd0);
    send_item(shte_pkg::OP_FIND, 64'h0000_0000_0000_0080, 32'd7, 32'd0);
    send_item(shte_pkg::OP_INSERT, '1, '1, 32'h5555_aaaa);
    send_item(shte_pkg::OP_INSERT, 64'h7f, 32'h0000_0001, 32'hdead_beef);
    send_item(shte_pkg::OP_DELETE, '1, '1, 32'd0);
    send_item(shte_pkg::OP_DELETE, '1, '1, 32'd0);
    send_item(shte_pkg::OP_FIND, '1, '1, 32'd0);
    send_item(shte_pkg::OP_INSERT, '1, 32'h8000_0000, 32'h8000_0001);
    send_item(shte_pkg::OP_CLEAR, 64'd0, 32'd0, 32'd0);
    send_item(shte_pkg::OP_FIND, 64'd0, 32'd0, 32'd0);
  endtask

  // Smallest table: fill it, overflow, delete one, claim it back.
  task automatic test_full_table();
    write_slots(11'd4);
    for (int i = 0; i < 4; i++)
      send_item(shte_pkg::OP_INSERT, {$urandom, $urandom}, 32'h100 + i, $urandom);
    send_item(shte_pkg::OP_INSERT, {$urandom, $urandom}, 32'hffff, 32'h1);
    send_item(shte_pkg::OP_DELETE, pool_hash[1], pool_key[1], 32'd0);
    send_item(shte_pkg::OP_INSERT, {$urandom, $urandom}, 32'hfffe, 32'h2);
    send_item(shte_pkg::OP_FIND, pool_hash[0], pool_key[0], 32'd0);
  endtask

  // Odd, clamped and maximal register values.
  task automatic test_slot_register();
    logic [10:0] corner_vals [4] = '{11'd0, 11'd13, 11'd2047, 11'd1024};
    foreach (corner_vals[i]) begin
      write_slots(corner_vals[i]);
      send_item(shte_pkg::OP_INSERT, {$urandom, $urandom}, $urandom, $urandom);
      send_item(shte_pkg::OP_INSERT, {$urandom, $urandom}, $urandom, $urandom);
      send_item(shte_pkg::OP_FIND, pool_hash[0], pool_key[0], 32'd0);
    end
  endtask

  // Mostly well-formed traffic on keys already in the table; tags come from a
  // narrow set so that tag hits with a different key occur often.
  task automatic random_item();
    int unsigned pick, sel;
    logic [63:0] h;
    logic [31:0] k;
    pick = $urandom_range(99);
    sel = (pool_hash.size() != 0) ? $urandom_range(pool_hash.size() - 1) : 0;
    h = {$urandom, $urandom};
    if ($urandom_range(1)) h[6:0] = $urandom_range(3);
    if ($urandom_range(1)) h[63:16] = '0;
    k = $urandom_range(1) ? $urandom_range(15) : $urandom;
    if (pick < 2)
      send_item(shte_pkg::OP_CLEAR, {$urandom, $urandom}, $urandom, $urandom);
    else if (pick < 30 && pool_hash.size() != 0)
      send_item(shte_pkg::OP_FIND, pool_hash[sel], pool_key[sel], $urandom);
    else if (pick < 45 && pool_hash.size() != 0)
      send_item(shte_pkg::OP_INSERT, pool_hash[sel], pool_key[sel], $urandom);
    else if (pick < 70)
      send_item(shte_pkg::OP_INSERT, h, k, $urandom);
    else if (pick < 88 && pool_hash.size() != 0)
      send_item(shte_pkg::OP_DELETE, pool_hash[sel], pool_key[sel], $urandom);
    else
      send_item(2'($urandom_range(3)), {$urandom, $urandom}, $urandom, $urandom);
  endtask

  task automatic test_random_traffic(int unsigned idle_pct, int unsigned items);
    logic [10:0] sizes [8] = '{11'd8, 11'd16, 11'd4, 11'd32, 11'd21, 11'd64, 11'd12, 11'd3};
    sender_idle_pct = idle_pct;
    for (int unsigned i = 0; i < items; i++) begin
      if (i % 50 == 0) write_slots(sizes[$urandom_range(7)]);
      random_item();
    end
    // a short stretch on the full-size table
    write_slots(11'd1024);
    for (int i = 0; i < 6; i++) random_item();
  endtask

  initial begin
    failed = 1'b0;
    cycle_cnt = 0;
    sender_idle_pct = 9;
    slots_reg = 11'd1024;
    empty_table();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_full_table();
    test_slot_register();
    test_random_traffic(9, 400);
    test_random_traffic(57, 400);
    test_random_traffic(0, 400);

    drain_results();
    repeat (64) @(posedge clk);
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
